// ===== hdl/lkt_pkg.sv =====
`timescale 1ns / 1ps

package lkt_pkg;

    // Fixed field widths.
    localparam int KEY_W = 64;
    localparam int OCC_W = 7;

    // Default number of keys the tracker holds.
    localparam int CAPACITY_DEF = 64;

    // Token that travels down the cell chain, one cell per cycle while the chain is not stalled.
    typedef struct packed {
        logic [KEY_W-1:0] key;     // key being looked up
        logic [KEY_W-1:0] carry;   // key displaced so far, written into the next cell
        logic             found;   // key matched a held entry
        logic             placed;  // carry landed in an empty cell
    } tok_t;

endpackage

// ===== hdl/lkt_if.sv =====
`timescale 1ns / 1ps

// Input channel: one key per transaction.
interface lkt_key_if;
    logic                      valid;
    logic                      ready;
    logic [lkt_pkg::KEY_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink (input valid, input key, output ready);
endinterface

// Output channel: one lookup result per transaction.
interface lkt_result_if;
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic                      evict_valid;
    logic [lkt_pkg::KEY_W-1:0] evicted_key;
    logic [lkt_pkg::OCC_W-1:0] occupancy;

    modport source (output valid, output hit, output evict_valid, output evicted_key,
                    output occupancy, input ready);
    modport sink (input valid, input hit, input evict_valid, input evicted_key,
                  input occupancy, output ready);
endinterface

// ===== hdl/lru_key_tracker.sv =====
`timescale 1ns / 1ps
// Each accepted key is registered in every cell in turn before its result is offered.
// Throughput: one transaction per cycle unless stalled; keys walk one cell per cycle.
// A held result at the last cell stalls the whole chain; bubbles stay where they are.
// Reset clears the occupancy flags, the in-flight tokens and the key count at once.
// Stored keys are not cleared and no clearing pass runs after reset.

module lru_key_tracker
#(
    parameter int CAPACITY = lkt_pkg::CAPACITY_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    lkt_key_if.sink             req,
    lkt_result_if.source        rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = (CNT_W > lkt_pkg::OCC_W) ? CNT_W : lkt_pkg::OCC_W;

    logic [CAPACITY:0]    chain_valid;
    lkt_pkg::tok_t        chain_tok [CAPACITY+1];
    logic [CAPACITY-1:0]  occ_vec;
    logic                 advance;
    logic                 tail_valid;
    lkt_pkg::tok_t        tail_tok;
    logic                 evict;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [SUM_W-1:0]     occ_wide;

    // The chain moves unless a finished result is waiting at the tail.
    assign advance   = !tail_valid || rsp.ready;
    assign req.ready = advance;

    // A new key enters as its own carry, so the front cell always takes it.
    assign chain_valid[0]     = req.valid;
    assign chain_tok[0].key   = req.key;
    assign chain_tok[0].carry = req.key;
    assign chain_tok[0].found = 1'b0;
    assign chain_tok[0].placed = 1'b0;

    // Row of cells, most recent entry first.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        lkt_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[i]),
            .in_tok    (chain_tok[i]),
            .out_valid (chain_valid[i+1]),
            .out_tok   (chain_tok[i+1]),
            .occupied  (occ_vec[i])
        );
    end

    assign tail_valid = chain_valid[CAPACITY];
    assign tail_tok   = chain_tok[CAPACITY];

    // A token that neither matched nor found room pushed the last key out.
    assign evict = !tail_tok.found && !tail_tok.placed;

    // Key count, advanced in result order as each transaction leaves.
    always_comb
    begin
        count_next = count_reg;
        if (rsp.valid && rsp.ready && tail_tok.placed)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign occ_wide = SUM_W'(count_reg) + SUM_W'(tail_tok.placed);

    // Result drive.
    assign rsp.valid       = tail_valid;
    assign rsp.hit         = tail_tok.found;
    assign rsp.evict_valid = evict;
    assign rsp.evicted_key = evict ? tail_tok.carry : '0;
    assign rsp.occupancy   = occ_wide[lkt_pkg::OCC_W-1:0];

`ifndef SYNTHESIS
    // Occupied cells always form a contiguous run from the front.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec + 1'b1) & occ_vec) == '0)
    else $error("occupied cells are not contiguous");

    // The key count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
    else $error("key count above capacity");

    // An eviction only happens with a full store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && evict) |-> (count_reg == CNT_W'(CAPACITY)))
    else $error("eviction with free room");

    // A key that fills an empty cell leaves a store that was not full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && tail_tok.placed) |-> (count_reg < CNT_W'(CAPACITY)))
    else $error("insertion into a full store");

    // A stalled result keeps the chain frozen.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> $stable(occ_vec))
    else $error("chain moved while the result stalled");
`endif

endmodule

// ===== hdl/lkt_cell.sv =====
`timescale 1ns / 1ps

module lkt_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          in_valid,
    input  lkt_pkg::tok_t in_tok,
    output logic          out_valid,
    output lkt_pkg::tok_t out_tok,
    output logic          occupied
);

    logic                      occ_reg;
    logic                      occ_next;
    logic [lkt_pkg::KEY_W-1:0] entry_reg;
    logic [lkt_pkg::KEY_W-1:0] entry_next;
    logic                      tok_valid_reg;
    lkt_pkg::tok_t             tok_reg;
    lkt_pkg::tok_t             tok_next;

    // Process the arriving token against the held entry.
    always_comb
    begin
        tok_next   = in_tok;
        entry_next = entry_reg;
        occ_next   = occ_reg;
        if (in_valid && !in_tok.found && !in_tok.placed)
        begin
            priority if (occ_reg && (entry_reg == in_tok.key))
            begin
                // Hit here: the displaced key fills the hole and the chain below holds.
                entry_next     = in_tok.carry;
                tok_next.found = 1'b1;
            end
            else if (!occ_reg)
            begin
                // First empty cell: the displaced key lands here.
                entry_next      = in_tok.carry;
                occ_next        = 1'b1;
                tok_next.placed = 1'b1;
            end
            else
            begin
                // Shift: take the carry, hand the old entry on.
                entry_next     = in_tok.carry;
                tok_next.carry = entry_reg;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            occ_reg       <= occ_next;
            tok_valid_reg <= in_valid;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            entry_reg <= entry_next;
            tok_reg   <= tok_next;
        end
    end

    assign out_valid = tok_valid_reg;
    assign out_tok   = tok_reg;
    assign occupied  = occ_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH      = lkt_pkg::CAPACITY_DEF;
    localparam int POOL_SIZE  = 96;
    localparam int HOT_SIZE   = 12;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        logic                      hit;
        logic                      evict_valid;
        logic [lkt_pkg::KEY_W-1:0] evicted_key;
        logic [lkt_pkg::OCC_W-1:0] occupancy;
    } lookup_result_t;

    logic clk;
    logic rst_n;

    lkt_key_if    key_ch ();
    lkt_result_if result_ch ();

    lru_key_tracker #(
        .CAPACITY (DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (key_ch),
        .rsp   (result_ch)
    );

    // Mirror of the tracker: held keys ordered from most recent (index 0) downward.
    logic [lkt_pkg::KEY_W-1:0] held_keys [DEPTH];
    int                        held_count;

    lookup_result_t            pending_results [$];
    logic [lkt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
    int                        error_count;
    int                        src_idle_pct;
    int                        snk_stall_pct;
    int                        idle_cycles;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [lkt_pkg::KEY_W-1:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // Applies one lookup to the mirror and returns the result the tracker must produce.
    function automatic lookup_result_t track_recency(input logic [lkt_pkg::KEY_W-1:0] k);
        lookup_result_t r;
        int             pos;
        int             upto;
        int             i;
        r   = '0;
        pos = -1;
        for (i = 0; i < held_count; i++)
        begin
            if (pos < 0 && held_keys[i] == k)
            begin
                pos = i;
            end
        end
        if (pos >= 0)
        begin
            r.hit = 1'b1;
            upto  = pos;
        end
        else if (held_count < DEPTH)
        begin
            upto       = held_count;
            held_count = held_count + 1;
        end
        else
        begin
            // A miss on a full store pushes out the least recent key.
            r.evict_valid = 1'b1;
            r.evicted_key = held_keys[DEPTH-1];
            upto          = DEPTH - 1;
        end
        for (i = upto; i > 0; i--)
        begin
            held_keys[i] = held_keys[i-1];
        end
        held_keys[0] = k;
        r.occupancy  = held_count[lkt_pkg::OCC_W-1:0];
        return r;
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    // Sends one key transaction, with a random gap before it; returns at a falling edge.
    task automatic send_key(input logic [lkt_pkg::KEY_W-1:0] k);
        while ($urandom_range(99) < src_idle_pct)
        begin
            key_ch.valid <= 1'b0;
            @(negedge clk);
        end
        key_ch.valid <= 1'b1;
        key_ch.key   <= k;
        do
        begin
            @(posedge clk);
        end
        while (!key_ch.ready);
        pending_results.push_back(track_recency(k));
        @(negedge clk);
    endtask

    // Result side back-pressure, changed at each falling edge.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Compare each result transaction with the oldest pending expectation.
    always @(posedge clk)
    begin : check_results
        lookup_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                note_failure($sformatf("result with no pending lookup: %s",
                                       $sformatf("hit=%0b evict=%0b key=%h occ=%0d",
                                                 result_ch.hit, result_ch.evict_valid,
                                                 result_ch.evicted_key,
                                                 result_ch.occupancy)));
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.hit !== want.hit)
                begin
                    note_failure($sformatf("hit: expected %0b, got %0b",
                                           want.hit, result_ch.hit));
                end
                if (result_ch.evict_valid !== want.evict_valid)
                begin
                    note_failure($sformatf("evict_valid: expected %0b, got %0b",
                                           want.evict_valid, result_ch.evict_valid));
                end
                if (result_ch.evicted_key !== want.evicted_key)
                begin
                    note_failure($sformatf("evicted_key: expected %h, got %h",
                                           want.evicted_key, result_ch.evicted_key));
                end
                if (result_ch.occupancy !== want.occupancy)
                begin
                    note_failure($sformatf("occupancy: expected %0d, got %0d",
                                           want.occupancy, result_ch.occupancy));
                end
            end
        end
    end

    // Watchdog: ends the run if no transaction moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((key_ch.valid && key_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("lru_key_tracker verification failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Field extremes, hits at the front and below it, single-bit and alternating keys.
    task automatic test_directed();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_key('0);
        send_key('1);
        send_key('0);
        send_key('0);
        send_key(64'hAAAA_AAAA_AAAA_AAAA);
        send_key(64'h5555_5555_5555_5555);
        send_key(64'hAAAA_AAAA_AAAA_AAAA);
        send_key(64'h8000_0000_0000_0000);
        send_key(64'h0000_0000_0000_0001);
        send_key('1);
        send_key(64'h0000_0000_0000_0001);
        send_key(64'h8000_0000_0000_0000);
    endtask

    // Fill past capacity with a cyclic sequence so every lookup misses, evicting once full,
    // then cycle exactly a store's worth of keys so every hit is on the least recent entry.
    task automatic test_thrash_and_deep_hits();
        logic [lkt_pkg::KEY_W-1:0] ring [DEPTH+1];
        int                        lap;
        int                        i;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        for (i = 0; i <= DEPTH; i++)
        begin
            ring[i] = rand_key();
        end
        for (lap = 0; lap < 3; lap++)
        begin
            for (i = 0; i <= DEPTH; i++)
            begin
                send_key(ring[i]);
            end
        end
        for (lap = 0; lap < 2; lap++)
        begin
            for (i = 1; i <= DEPTH; i++)
            begin
                send_key(ring[i]);
            end
        end
    endtask

    // Mixed traffic from a key pool larger than the store: frequent hits near the
    // front, deep hits, misses with eviction, fresh keys and the field extremes.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        logic [lkt_pkg::KEY_W-1:0] k;
        int                        pick;
        int                        i;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                k = key_pool[$urandom_range(HOT_SIZE-1)];
            end
            else if (pick < 85)
            begin
                k = key_pool[$urandom_range(POOL_SIZE-1)];
            end
            else if (pick < 97)
            begin
                k = rand_key();
            end
            else
            begin
                k = ($urandom_range(1) == 0) ? '0 : '1;
            end
            if ($urandom_range(9) == 0)
            begin
                key_pool[$urandom_range(POOL_SIZE-1)] = rand_key();
            end
            send_key(k);
        end
    endtask

    // Main sequence.
    initial
    begin : main_flow
        int i;
        rst_n         = 1'b0;
        key_ch.valid  = 1'b0;
        key_ch.key    = '0;
        held_count    = 0;
        error_count   = 0;
        idle_cycles   = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        for (i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i] = rand_key();
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_thrash_and_deep_hits();
        test_random_traffic(0, 0, 340);
        test_random_traffic(48, 0, 325);
        test_random_traffic(0, 48, 325);
        test_random_traffic(22, 22, 325);

        // Drain the pipeline, then watch for stray results.
        key_ch.valid  <= 1'b0;
        snk_stall_pct = 0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DEPTH + 8) @(posedge clk);

        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("lru_key_tracker verification clean");
        end
        else
        begin
            $display("lru_key_tracker verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lkt_pkg.sv
hdl/lkt_if.sv
hdl/lkt_cell.sv
hdl/lru_key_tracker.sv
tb/tb_top.sv
